// ===== rtl/core/aip_pkg.sv =====
// Package for the ASCII integer parser: parser states, status codes,
// character constants and the result record. No dependencies.
package aip_pkg;

  localparam int unsigned ValueWidth = 64;

  typedef enum logic [2:0] {
    ST_START  = 3'd0,
    ST_ZERO   = 3'd1,
    ST_DEC    = 3'd2,
    ST_MINUS  = 3'd3,
    ST_HEXPRE = 3'd4,
    ST_HEX    = 3'd5,
    ST_TRAIL  = 3'd6
  } parse_state_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_CHAR = 2'd1,
    STAT_UOVF = 2'd2,
    STAT_SOVF = 2'd3
  } status_t;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChMinus = 8'h2d;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowF  = 8'h66;
  localparam logic [7:0] ChLowX  = 8'h78;

  typedef struct packed {
    logic [ValueWidth-1:0] value;
    status_t               status;
  } aip_result_t;

endpackage

// ===== rtl/core/aip_if.sv =====
// Channel interfaces for the ASCII integer parser: character items in,
// result items out. No dependencies.
interface aip_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       is_last;

  modport source (output valid, output char_code, output is_last, input ready);
  modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

interface aip_result_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;
  logic [1:0]  status;

  modport source (output valid, output value, output status, input ready);
  modport sink   (input valid, input value, input status, output ready);
endinterface

// ===== rtl/core/aip_parse_core.sv =====
// Parser state registers and per-character next-state logic.
// Depends on aip_pkg.
module aip_parse_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [7:0]          char_code,
  input  logic                is_last,
  output logic                res_push,
  output aip_pkg::aip_result_t res
);
  import aip_pkg::*;

  parse_state_t          state_r, state_nxt, state_c;
  logic [ValueWidth-1:0] acc_r, acc_nxt, acc_c;
  logic                  neg_r, neg_nxt, neg_c;
  status_t               err_r, err_nxt, err_c;

  logic                  is_dec, is_hexl;
  logic [3:0]            dval, hval;
  logic [ValueWidth+3:0] mul10;
  logic                  ovf10, ovf16;
  logic [ValueWidth-1:0] acc_dec, acc_hex;

  assign is_dec  = (char_code >= ChZero) && (char_code <= ChNine);
  assign is_hexl = (char_code >= ChLowA) && (char_code <= ChLowF);
  assign dval    = char_code[3:0];
  // 'a'..'f' have low nibbles 1..6
  assign hval    = is_hexl ? (char_code[3:0] + 4'd9) : char_code[3:0];

  // acc*10 + d as shift-add with four guard bits for the exact overflow test
  assign mul10   = ({4'b0, acc_r} << 3) + ({4'b0, acc_r} << 1) + {64'b0, dval};
  assign ovf10   = |mul10[ValueWidth+3:ValueWidth];
  assign acc_dec = mul10[ValueWidth-1:0];
  assign ovf16   = |acc_r[ValueWidth-1:ValueWidth-4];
  assign acc_hex = {acc_r[ValueWidth-5:0], hval};

  // one character through the automaton
  always_comb begin
    state_c = state_r;
    acc_c   = acc_r;
    neg_c   = neg_r;
    err_c   = err_r;
    if (err_r == STAT_OK) begin
      unique case (state_r)
        ST_START: begin
          if (char_code == ChZero) begin
            state_c = ST_ZERO;
            acc_c   = '0;
          end else if (is_dec) begin
            state_c = ST_DEC;
            acc_c   = {60'b0, dval};
          end else if (char_code == ChMinus) begin
            state_c = ST_MINUS;
            neg_c   = 1'b1;
          end else if (char_code != ChSpace) begin
            err_c   = STAT_CHAR;
          end
        end
        ST_ZERO: begin
          if (is_dec) begin
            state_c = ST_DEC;
            if (ovf10) err_c = STAT_UOVF;
            else       acc_c = acc_dec;
          end else if (char_code == ChLowX) begin
            state_c = ST_HEXPRE;
          end else if (char_code == ChSpace) begin
            state_c = ST_TRAIL;
          end else begin
            err_c   = STAT_CHAR;
          end
        end
        ST_DEC: begin
          if (is_dec) begin
            if (ovf10) err_c = STAT_UOVF;
            else       acc_c = acc_dec;
          end else if (char_code == ChSpace) begin
            state_c = ST_TRAIL;
          end else begin
            err_c   = STAT_CHAR;
          end
        end
        ST_MINUS: begin
          if (char_code == ChZero) begin
            state_c = ST_ZERO;
          end else if (is_dec) begin
            state_c = ST_DEC;
            acc_c   = {60'b0, dval};
          end else begin
            err_c   = STAT_CHAR;
          end
        end
        ST_HEXPRE, ST_HEX: begin
          if (is_dec || is_hexl) begin
            state_c = ST_HEX;
            if (ovf16) err_c = STAT_UOVF;
            else       acc_c = acc_hex;
          end else begin
            err_c   = STAT_CHAR;
          end
        end
        ST_TRAIL: begin
          if (char_code != ChSpace) err_c = STAT_CHAR;
        end
        default: begin
          err_c = STAT_CHAR;
        end
      endcase
    end
  end

  // register update: the last character returns everything to reset values
  always_comb begin
    state_nxt = state_r;
    acc_nxt   = acc_r;
    neg_nxt   = neg_r;
    err_nxt   = err_r;
    if (accept) begin
      if (is_last) begin
        state_nxt = ST_START;
        acc_nxt   = '0;
        neg_nxt   = 1'b0;
        err_nxt   = STAT_OK;
      end else begin
        state_nxt = state_c;
        acc_nxt   = acc_c;
        neg_nxt   = neg_c;
        err_nxt   = err_c;
      end
    end
  end

  // result from the post-character values
  always_comb begin
    res_push   = accept && is_last;
    res.value  = '0;
    res.status = err_c;
    if (err_c == STAT_OK) begin
      if (neg_c) begin
        if (acc_c[ValueWidth-1]) res.status = STAT_SOVF;
        else                     res.value  = (~acc_c) + 64'd1;
      end else begin
        res.value = acc_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_START;
      acc_r   <= '0;
      neg_r   <= 1'b0;
      err_r   <= STAT_OK;
    end else begin
      state_r <= state_nxt;
      acc_r   <= acc_nxt;
      neg_r   <= neg_nxt;
      err_r   <= err_nxt;
    end
  end

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && is_last |=> state_r == ST_START && acc_r == '0 && !neg_r && err_r == STAT_OK)
    else $error("state not cleared after last item");

  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !is_last && err_r != STAT_OK |=> err_r == $past(err_r) && acc_r == $past(acc_r))
    else $error("error state changed before last item");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    res_push && res.status != STAT_OK |-> res.value == '0)
    else $error("failed result carries nonzero value");

endmodule

// ===== rtl/core/aip_result_reg.sv =====
// Output register for result items; gives the input side its ready.
// Depends on aip_pkg and aip_result_if.
module aip_result_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  aip_pkg::aip_result_t res,
  output logic                in_ready,
  aip_result_if.source        out_ch
);
  import aip_pkg::*;

  logic        valid_r, valid_nxt;
  aip_result_t data_r, data_nxt;

  assign in_ready = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (out_ch.ready) valid_nxt = 1'b0;
    if (push) begin
      valid_nxt = 1'b1;
      data_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= valid_nxt;
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign out_ch.valid  = valid_r;
  assign out_ch.value  = data_r.value;
  assign out_ch.status = data_r.status;

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> in_ready)
    else $error("result pushed into a full output register");

  a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> valid_r && data_r == $past(res))
    else $error("pushed result not presented");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && out_ch.ready && !push |=> !valid_r)
    else $error("taken result still presented");

endmodule

// ===== rtl/core/ascii_integer_parser.sv =====
// Top level of the ASCII integer parser: parse core plus output register.
// Depends on aip_pkg, aip_if, aip_parse_core, aip_result_reg.
//
// channel   dir  handshake     payload
// in_ch     in   valid/ready   char_code[7:0], is_last
// out_ch    out  valid/ready   value[63:0], status[1:0]
//
// One character item per cycle while in_ch.ready is high; the multiply-by-base
// and add are combinational ahead of the parser state registers.
// A result item is registered and appears the cycle after its last character.
// in_ch.ready drops only while a result is held and out_ch.ready is low.
// Synchronous active-low reset returns the parser to its start state.
module ascii_integer_parser (
  input  logic         clk,
  input  logic         rst_n,
  aip_char_if.sink     in_ch,
  aip_result_if.source out_ch
);
  import aip_pkg::*;

  logic        in_ready;
  logic        accept;
  logic        res_push;
  aip_result_t res;

  assign in_ch.ready = in_ready;
  assign accept      = in_ch.valid && in_ready;

  aip_parse_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .char_code (in_ch.char_code),
    .is_last   (in_ch.is_last),
    .res_push  (res_push),
    .res       (res)
  );

  aip_result_reg u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_push),
    .res      (res),
    .in_ready (in_ready),
    .out_ch   (out_ch)
  );

endmodule
